// ----- design/dart_pkg.sv -----
package dart_pkg;

	// Default table depth
	localparam int RULE_DEPTH_DEF = 64;

	// Request kinds carried on s_tuser
	localparam logic [1:0] REQ_CHECK  = 2'd0;
	localparam logic [1:0] REQ_APPEND = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;

	// Device type wildcard and the "any number" code
	localparam logic [1:0]  TYPE_ALL = 2'd0;
	localparam logic [31:0] NUM_ANY  = 32'hFFFF_FFFF;

	// Field widths
	localparam int REQ_W    = 2;
	localparam int TYPE_W   = 2;
	localparam int NUM_W    = 32;
	localparam int ACC_W    = 3;
	localparam int COUNT_W  = 7;
	localparam int NUMS_W   = 2 * NUM_W;
	localparam int ATTR_W   = TYPE_W + ACC_W + 1;

	// Stream widths, padded to whole bytes
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 16;

	// Request fields that the match unit compares against
	typedef struct packed {
		logic [TYPE_W-1:0] dev_type;
		logic [NUM_W-1:0]  major;
		logic [NUM_W-1:0]  minor;
		logic [ACC_W-1:0]  access;
	} check_req_t;

	// One stored rule as read back from the tables
	typedef struct packed {
		logic [NUMS_W-1:0] nums;   // major high, minor low
		logic [ATTR_W-1:0] attr;   // allow, access, type
	} rule_t;

endpackage

// ----- design/dart_ram.sv -----
module dart_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Single write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/dart_match.sv -----
module dart_match (
	input  dart_pkg::check_req_t req,
	input  dart_pkg::rule_t      rule,
	output logic                 hit,
	output logic                 allow
);
	import dart_pkg::*;

	logic [TYPE_W-1:0] r_type;
	logic [ACC_W-1:0]  r_acc;
	logic [NUM_W-1:0]  r_major;
	logic [NUM_W-1:0]  r_minor;
	logic              type_ok;
	logic              major_ok;
	logic              minor_ok;
	logic              acc_ok;

	// Unpack the stored rule
	assign r_type  = rule.attr[TYPE_W-1:0];
	assign r_acc   = rule.attr[TYPE_W+ACC_W-1:TYPE_W];
	assign allow   = rule.attr[ATTR_W-1];
	assign r_major = rule.nums[NUMS_W-1:NUM_W];
	assign r_minor = rule.nums[NUM_W-1:0];

	// Wildcards on type and numbers; request access must be a subset of the rule
	assign type_ok  = (r_type == TYPE_ALL) || (r_type == req.dev_type);
	assign major_ok = (r_major == NUM_ANY) || (r_major == req.major);
	assign minor_ok = (r_minor == NUM_ANY) || (r_minor == req.minor);
	assign acc_ok   = ((r_acc & req.access) == req.access);

	assign hit = type_ok && major_ok && minor_ok && acc_ok;

endmodule

// ----- design/device_access_rule_table.sv -----
// Device access rule table: holds an ordered list of up to RULE_DEPTH rules and
// answers one request at a time from the s_ stream (kind on s_tuser). An append,
// a clear, or a check with the table disabled or the list empty goes straight
// from idle to the finish state. Any other check reads the rules back one per
// cycle through the registered read port of the rule memory and compares them in
// a single match unit, the last matching rule deciding (allow when none matches).
// The input is taken again as soon as a request is finished, even while its
// result still waits in the output register. The rule memory needs no clearing
// after reset.
module device_access_rule_table #(
	parameter int RULE_DEPTH = dart_pkg::RULE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Configuration write: bit 0 enabled
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [0:0]                       cfg_data,
	// Requests
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// s_tdata from bit 0: dev_type[2], major[32], minor[32], access[3], rule_allow[1], pad
	input  logic [dart_pkg::IN_DATA_W-1:0]   s_tdata,
	// s_tuser: req_type[2]
	input  logic [dart_pkg::REQ_W-1:0]       s_tuser,
	// Results
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// m_tdata from bit 0: permitted[1], status[1], rule_count[7], pad
	output logic [dart_pkg::OUT_DATA_W-1:0]  m_tdata
);
	import dart_pkg::*;

	localparam int AW = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
	localparam int CW = $clog2(RULE_DEPTH + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]        state_q;
	logic              enabled_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     issue_q;
	logic              pend_s1;
	check_req_t        req_q;
	logic              perm_q;
	logic              status_q;
	logic              m_tvalid_q;
	logic              out_perm_q;
	logic              out_status_q;
	logic [COUNT_W-1:0] out_count_q;

	logic              in_acc;
	logic [REQ_W-1:0]  in_req;
	check_req_t        in_fields;
	logic              in_allow;
	logic              full;
	logic              ram_we;
	logic              ram_re;
	rule_t             rule_rd;
	logic              hit;
	logic              hit_allow;
	logic              out_free;

	// Configuration port never stalls
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
		end else if (cfg_valid) begin
			enabled_q <= cfg_data[0];
		end
	end

	// Input unpacking
	assign s_tready           = (state_q == ST_IDLE);
	assign in_acc             = s_tvalid && s_tready;
	assign in_req             = s_tuser;
	assign in_fields.dev_type = s_tdata[1:0];
	assign in_fields.major    = s_tdata[33:2];
	assign in_fields.minor    = s_tdata[65:34];
	assign in_fields.access   = s_tdata[68:66];
	assign in_allow           = s_tdata[69];
	assign full               = (count_q >= CW'(RULE_DEPTH));

	// Append writes straight into the next free entry
	assign ram_we = in_acc && (in_req == REQ_APPEND) && !full;
	assign ram_re = (state_q == ST_SCAN) && (issue_q < count_q);

	dart_ram #(
		.WIDTH (NUMS_W),
		.DEPTH (RULE_DEPTH)
	) u_nums (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata ({in_fields.major, in_fields.minor}),
		.re    (ram_re),
		.raddr (issue_q[AW-1:0]),
		.rdata (rule_rd.nums)
	);

	dart_ram #(
		.WIDTH (ATTR_W),
		.DEPTH (RULE_DEPTH)
	) u_attr (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata ({in_allow, in_fields.access, in_fields.dev_type}),
		.re    (ram_re),
		.raddr (issue_q[AW-1:0]),
		.rdata (rule_rd.attr)
	);

	// Shared compare unit
	dart_match u_match (
		.req   (req_q),
		.rule  (rule_rd),
		.hit   (hit),
		.allow (hit_allow)
	);

	assign out_free = !m_tvalid_q || m_tready;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			issue_q <= '0;
			pend_s1 <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					pend_s1 <= 1'b0;
					issue_q <= '0;
					if (in_acc) begin
						case (in_req)
							REQ_CHECK: begin
								if (enabled_q && (count_q != '0)) begin
									state_q <= ST_SCAN;
								end else begin
									state_q <= ST_FIN;
								end
							end
							REQ_APPEND: begin
								if (!full) begin
									count_q <= count_q + CW'(1);
								end
								state_q <= ST_FIN;
							end
							REQ_CLEAR: begin
								count_q <= '0;
								state_q <= ST_FIN;
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_SCAN: begin
					pend_s1 <= ram_re;
					if (ram_re) begin
						issue_q <= issue_q + CW'(1);
					end else if (!pend_s1) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request latch and running verdict
	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q    <= in_fields;
			perm_q   <= (in_req == REQ_CHECK);
			status_q <= (in_req == REQ_APPEND) && full;
		end else if (pend_s1 && hit) begin
			perm_q <= hit_allow;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == ST_FIN) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FIN) && out_free) begin
			out_perm_q   <= perm_q;
			out_status_q <= status_q;
			out_count_q  <= COUNT_W'(count_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_DATA_W - COUNT_W - 2){1'b0}}, out_count_q, out_status_q,
		out_perm_q};

	// Checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(RULE_DEPTH))
		else $error("rule count above table depth");

	a_pend_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (state_q == ST_SCAN))
		else $error("rule compare outside of a scan");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !ram_we && (issue_q <= count_q))
		else $error("rule table written or overrun during a scan");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[1]) |-> (m_tdata[8:2] == COUNT_W'(RULE_DEPTH)) && !m_tdata[0])
		else $error("full status with a table that is not full");

endmodule

// ----- dv/tb_device_access_rule_table.sv -----
module tb_device_access_rule_table;
	import dart_pkg::*;

	localparam int RULE_DEPTH     = RULE_DEPTH_DEF;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 400;
	localparam int TAIL_CYCLES    = 80;

	// Codes the package leaves unnamed
	localparam logic [REQ_W-1:0]  REQ_UNKNOWN = 2'd3;
	localparam logic [TYPE_W-1:0] TYPE_BLOCK  = 2'd1;
	localparam logic [TYPE_W-1:0] TYPE_CHAR   = 2'd2;
	localparam logic [TYPE_W-1:0] TYPE_ODD    = 2'd3;
	localparam logic [ACC_W-1:0]  ACC_NONE    = 3'd0;
	localparam logic [ACC_W-1:0]  ACC_READ    = 3'd1;
	localparam logic [ACC_W-1:0]  ACC_WRITE   = 3'd2;
	localparam logic [ACC_W-1:0]  ACC_MKNOD   = 3'd4;
	localparam logic [ACC_W-1:0]  ACC_ALL     = 3'd7;
	localparam logic              RULE_DENY   = 1'b0;
	localparam logic              RULE_ALLOW  = 1'b1;

	typedef struct packed {
		logic [REQ_W-1:0]  kind;
		logic [TYPE_W-1:0] dev_type;
		logic [NUM_W-1:0]  major;
		logic [NUM_W-1:0]  minor;
		logic [ACC_W-1:0]  access;
		logic              allow;
	} dev_req_t;

	typedef struct packed {
		logic               permitted;
		logic               status;
		logic [COUNT_W-1:0] count;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [0:0] cfg_data = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic [REQ_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	device_access_rule_table DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// Shadow of the rule table
	rule_t rule_store [RULE_DEPTH];
	int    rules_held = 0;
	logic  rule_enable = 1'b0;

	dev_req_t pending_reqs[$];
	verdict_t verdicts_due[$];
	dev_req_t req_on_bus;
	bit req_fired = 1'b0;
	int taken_count = 0;
	int cfg_writes = 0;
	int failures = 0;
	int idle_cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int pressure_at = 32'h7fff_ffff;
	int hold_left = 0;
	bit hold_done = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic bit rule_matches(rule_t rl, dev_req_t r);
		logic [TYPE_W-1:0] rtype;
		logic [ACC_W-1:0]  racc;
		logic [NUM_W-1:0]  rmaj;
		logic [NUM_W-1:0]  rmin;
		rtype = rl.attr[TYPE_W-1:0];
		racc  = rl.attr[TYPE_W+ACC_W-1:TYPE_W];
		rmaj  = rl.nums[NUMS_W-1:NUM_W];
		rmin  = rl.nums[NUM_W-1:0];
		return (rtype == TYPE_ALL || rtype == r.dev_type) &&
			(rmaj == NUM_ANY || rmaj == r.major) &&
			(rmin == NUM_ANY || rmin == r.minor) &&
			((racc & r.access) == r.access);
	endfunction

	// Work out the answer to one request and update the shadow table
	function automatic verdict_t predict_verdict(dev_req_t r);
		verdict_t v;
		v = '0;
		case (r.kind)
			REQ_CHECK: begin
				v.permitted = 1'b1;
				if (rule_enable)
					for (int i = 0; i < rules_held; i++)
						if (rule_matches(rule_store[i], r))
							v.permitted = rule_store[i].attr[ATTR_W-1];
			end
			REQ_APPEND: begin
				if (rules_held >= RULE_DEPTH) begin
					v.status = 1'b1;
				end else begin
					rule_store[rules_held] = {r.major, r.minor, r.allow, r.access, r.dev_type};
					rules_held++;
				end
			end
			REQ_CLEAR: begin
				rules_held = 0;
			end
			default: ;
		endcase
		v.count = COUNT_W'(rules_held);
		return v;
	endfunction

	function automatic dev_req_t make_req(logic [REQ_W-1:0] kind, logic [TYPE_W-1:0] dtype,
			logic [NUM_W-1:0] major, logic [NUM_W-1:0] minor, logic [ACC_W-1:0] access,
			logic allow);
		dev_req_t r;
		r.kind = kind;
		r.dev_type = dtype;
		r.major = major;
		r.minor = minor;
		r.access = access;
		r.allow = allow;
		return r;
	endfunction

	// Small pool of numbers so that checks hit rules often
	function automatic logic [NUM_W-1:0] pick_number();
		case ($urandom_range(0, 7))
			0: return NUM_ANY;
			1, 2: return '0;
			3, 4: return NUM_W'($urandom_range(1, 3));
			default: return $urandom();
		endcase
	endfunction

	function automatic dev_req_t random_req(logic [REQ_W-1:0] kind);
		logic [TYPE_W-1:0] dtype;
		dtype = ($urandom_range(0, 15) == 0) ? TYPE_ODD : TYPE_W'($urandom_range(0, 2));
		return make_req(kind, dtype, pick_number(), pick_number(),
			ACC_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
	endfunction

	// Mostly clear / append run / checks sequences, with stray requests mixed in
	task automatic queue_random(int n, bit fill_first);
		int added;
		int burst;
		bit full_run;
		added = 0;
		full_run = fill_first;
		while (added < n) begin
			if (!full_run && $urandom_range(0, 9) == 0) begin
				pending_reqs.push_back(random_req(REQ_W'($urandom_range(0, 3))));
				added++;
			end else begin
				if (full_run)
					burst = RULE_DEPTH + 2;
				else if ($urandom_range(0, 7) == 0)
					burst = $urandom_range(RULE_DEPTH - 4, RULE_DEPTH + 2);
				else
					burst = $urandom_range(0, 8);
				if (full_run || $urandom_range(0, 3) != 0) begin
					pending_reqs.push_back(random_req(REQ_CLEAR));
					added++;
				end
				for (int i = 0; i < burst; i++) begin
					pending_reqs.push_back(random_req(REQ_APPEND));
					added++;
					if ($urandom_range(0, 2) == 0) begin
						pending_reqs.push_back(random_req(REQ_CHECK));
						added++;
					end
				end
				repeat ($urandom_range(2, 6)) begin
					pending_reqs.push_back(random_req(REQ_CHECK));
					added++;
				end
				full_run = 1'b0;
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || s_tvalid || verdicts_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_enable(logic value);
		int seen;
		seen = cfg_writes;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(negedge clk); while (cfg_writes == seen);
		cfg_valid <= 1'b0;
	endtask

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			failures++;
		end
	endtask

	// Request driver: holds the request until taken, then offers the next one
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || req_fired)) begin
			if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				req_on_bus = pending_reqs.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {2'b00, req_on_bus.allow, req_on_bus.access, req_on_bus.minor,
					req_on_bus.major, req_on_bus.dev_type};
				s_tuser <= req_on_bus.kind;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result receiver, with one long hold-off to back the block up
	always @(negedge clk) begin
		if (!hold_done && taken_count >= pressure_at) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Monitor: compare results, predict accepted requests, track the enable
	always @(posedge clk) begin
		req_fired = arst_n && s_tvalid && s_tready;
		if (arst_n && m_tvalid && m_tready) begin
			if (verdicts_due.size() == 0) begin
				$display("%0t: result with nothing expected, expected none, actual %h",
					$time, m_tdata);
				failures++;
			end else begin
				check_field("permitted", verdicts_due[0].permitted, m_tdata[0]);
				check_field("status", verdicts_due[0].status, m_tdata[1]);
				check_field("rule_count", verdicts_due[0].count, m_tdata[COUNT_W+1:2]);
				void'(verdicts_due.pop_front());
			end
		end
		if (req_fired) begin
			verdicts_due.push_back(predict_verdict(req_on_bus));
			taken_count++;
		end
		if (arst_n && cfg_valid && cfg_ready) begin
			rule_enable = cfg_data[0];
			cfg_writes++;
		end
	end

	// Watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("tb_device_access_rule_table: FAIL");
				$finish;
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 13;
		recv_idle_pct = 72;
		write_enable(1'b1);

		// Directed: default allow, last match wins, wildcards, odd type, full mask
		pending_reqs.push_back(make_req(REQ_CHECK, TYPE_CHAR, 1, 1, ACC_READ, RULE_DENY));
		pending_reqs.push_back(make_req(REQ_APPEND, TYPE_ALL, NUM_ANY, NUM_ANY, ACC_ALL,
			RULE_DENY));
		pending_reqs.push_back(make_req(REQ_CHECK, TYPE_CHAR, 1, 1, ACC_READ, RULE_DENY));
		pending_reqs.push_back(make_req(REQ_APPEND, TYPE_BLOCK, 8, NUM_ANY,
			ACC_READ | ACC_WRITE, RULE_ALLOW));
		pending_reqs.push_back(make_req(REQ_CHECK, TYPE_BLOCK, 8, 5, ACC_READ | ACC_WRITE,
			RULE_DENY));
		pending_reqs.push_back(make_req(REQ_CHECK, TYPE_BLOCK, 8, 5, ACC_ALL, RULE_DENY));
		pending_reqs.push_back(make_req(REQ_CHECK, TYPE_ALL, 8, 5, ACC_READ, RULE_DENY));
		pending_reqs.push_back(make_req(REQ_CHECK, TYPE_CHAR, 2, 2, ACC_NONE, RULE_DENY));
		pending_reqs.push_back(make_req(REQ_APPEND, TYPE_ODD, NUM_ANY, NUM_ANY, ACC_ALL,
			RULE_ALLOW));
		pending_reqs.push_back(make_req(REQ_CHECK, TYPE_ODD, NUM_ANY, 0, ACC_MKNOD,
			RULE_DENY));
		pending_reqs.push_back(make_req(REQ_CHECK, TYPE_CHAR, 3, 3, ACC_MKNOD, RULE_ALLOW));
		pending_reqs.push_back(make_req(REQ_UNKNOWN, TYPE_ODD, NUM_ANY, NUM_ANY, ACC_ALL,
			RULE_ALLOW));
		pending_reqs.push_back(make_req(REQ_CLEAR, TYPE_ALL, 0, 0, ACC_NONE, RULE_DENY));
		pending_reqs.push_back(make_req(REQ_CHECK, TYPE_BLOCK, 0, 0, ACC_ALL, RULE_DENY));
		pending_reqs.push_back(make_req(REQ_APPEND, TYPE_CHAR, 0, 0, ACC_NONE, RULE_DENY));
		pending_reqs.push_back(make_req(REQ_CHECK, TYPE_CHAR, 0, 0, ACC_NONE, RULE_ALLOW));
		pending_reqs.push_back(make_req(REQ_CHECK, TYPE_CHAR, 0, 0, ACC_READ, RULE_ALLOW));
		pending_reqs.push_back(make_req(REQ_APPEND, TYPE_CHAR, 32'hFFFF_FFFE, 32'hFFFF_FFFE,
			ACC_ALL, RULE_ALLOW));
		pending_reqs.push_back(make_req(REQ_CHECK, TYPE_CHAR, 32'hFFFF_FFFE, 32'hFFFF_FFFE,
			ACC_ALL, RULE_DENY));
		pending_reqs.push_back(make_req(REQ_CHECK, TYPE_CHAR, NUM_ANY, NUM_ANY, ACC_ALL,
			RULE_DENY));
		wait_drained();

		// Random, starting with a run that overfills the table
		queue_random(200, 1'b1);
		wait_drained();

		// Rules kept but ignored while disabled
		send_idle_pct = 72;
		recv_idle_pct = 13;
		write_enable(1'b0);
		queue_random(60, 1'b0);
		wait_drained();

		write_enable(1'b1);
		queue_random(140, 1'b0);
		wait_drained();

		// Full rate, with one long receiver hold-off
		send_idle_pct = 0;
		recv_idle_pct = 0;
		pressure_at = taken_count + 40;
		queue_random(150, 1'b0);
		wait_drained();

		repeat (TAIL_CYCLES) @(negedge clk);
		if (failures == 0 && verdicts_due.size() == 0) begin
			$display("tb_device_access_rule_table: PASS");
		end else begin
			$display("tb_device_access_rule_table: FAIL");
		end
		$finish;
	end

endmodule

// ----- device_access_rule_table.f -----
design/dart_pkg.sv
design/dart_ram.sv
design/dart_match.sv
design/device_access_rule_table.sv
dv/tb_device_access_rule_table.sv
